@@ design/sle_pkg.sv @@
// Shared types, constants and codes of the Sobel logo edge matcher.
`default_nettype none

package sle_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF    = 12;
  localparam int LOGO_DIM_BITS_DEF = 11;

  // Field widths
  localparam int PIX_W       = 8;
  localparam int WIN_TAPS    = 9;
  localparam int IN_DATA_W   = 80;
  localparam int COUNT_W     = 22;
  localparam int COUNT_OUT_W = 23;
  localparam int SUM_W       = 31;
  localparam int MEAN_W      = 8;
  localparam int SOB_W       = 10;
  localparam int MAG_W       = SOB_W + 1;
  localparam int OUT_FIELD_W = 3 * PIX_W + 2 * COUNT_OUT_W + MEAN_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int CORNER_W    = 2;
  localparam int LOGO_REG_W  = 11;
  localparam int VIDEO_REG_W = 12;
  localparam int MARGIN_W    = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOGO_CORNER    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOGO_WIDTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOGO_HEIGHT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_WIDTH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_HEIGHT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_MARGIN    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_PLANE   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_ENABLE = 3'd7;

  // Register reset values
  localparam logic [CORNER_W-1:0]    RST_LOGO_CORNER  = 2'd0;
  localparam logic [LOGO_REG_W-1:0]  RST_LOGO_WIDTH   = 11'd230;
  localparam logic [LOGO_REG_W-1:0]  RST_LOGO_HEIGHT  = 11'd130;
  localparam logic [VIDEO_REG_W-1:0] RST_VIDEO_WIDTH  = 12'd720;
  localparam logic [VIDEO_REG_W-1:0] RST_VIDEO_HEIGHT = 12'd576;
  localparam logic [MARGIN_W-1:0]    RST_EDGE_MARGIN  = 8'd0;

  // Arithmetic constants
  localparam logic [MAG_W-1:0]   CUT_LUMA   = 11'd127;
  localparam logic [MAG_W-1:0]   CUT_CHROMA = 11'd63;
  localparam logic [PIX_W-1:0]   PIX_MAX    = 8'hFF;
  localparam logic [MEAN_W-1:0]  MEAN_MAX   = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // Mean divider sequencing
  localparam int DIV_STEPS   = MEAN_W;
  localparam int DIV_COUNT_W = 3;
  localparam logic [DIV_COUNT_W-1:0] DIV_LAST = DIV_COUNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_RESTART,
    ST_LIMITS,
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load_bounds;
    logic load_limits;
    logic take;
    logic div_start;
    logic div_step;
    logic div_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_div;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/sle_div.sv @@
// Restoring divider for the saturated 8-bit mean intensity, one bit per step.
`default_nettype none

module sle_div #(
  parameter int DIVISOR_W = 2 * sle_pkg::LOGO_DIM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         start,
  input  logic                         step,
  input  logic [sle_pkg::SUM_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic [sle_pkg::MEAN_W-1:0]   quotient
);
  import sle_pkg::*;

  localparam int SH    = MEAN_W - 1;
  localparam int DSH_W = DIVISOR_W + SH;
  localparam int CW    = (SUM_W > DIVISOR_W + MEAN_W) ? SUM_W : DIVISOR_W + MEAN_W;

  logic [SUM_W-1:0]  rem;
  logic [DSH_W-1:0]  dsh;
  logic [MEAN_W-1:0] q;
  logic              sat;

  logic          fits;
  logic [CW-1:0] rem_diff;
  logic [CW-1:0] limit;

  assign fits     = CW'(rem) >= CW'(dsh);
  assign rem_diff = CW'(rem) - CW'(dsh);
  assign limit    = CW'({divisor, {MEAN_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= {divisor, {SH{1'b0}}};
      q   <= '0;
      // zero divisor or quotient past 255 both read as full scale
      sat <= (divisor == '0) || (CW'(dividend) >= limit);
    end else if (step) begin
      if (fits) begin
        rem <= rem_diff[SUM_W-1:0];
      end
      q   <= {q[MEAN_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  assign quotient = sat ? MEAN_MAX : q;

endmodule

`default_nettype wire

@@ design/sle_datapath.sv @@
// Datapath: configuration registers, area bounds, walker, Sobel, counts, output register.
`default_nettype none

module sle_datapath #(
  parameter int COORD_BITS    = sle_pkg::COORD_BITS_DEF,
  parameter int LOGO_DIM_BITS = sle_pkg::LOGO_DIM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sle_pkg::ctrl_cmd_t                cmd,
  output sle_pkg::dp_status_t               status,
  input  logic                              cfg_write,
  input  logic [sle_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sle_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [sle_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sle_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast
);
  import sle_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int LB     = LOGO_DIM_BITS;
  localparam int DW     = ((CB > LB) ? CB : LB) + 2;
  localparam int PROD_W = 2 * LB;

  localparam logic signed [DW-1:0] S_ZERO = '0;
  localparam logic signed [DW-1:0] S_ONE  = DW'(1);
  localparam logic signed [DW-1:0] S_TWO  = DW'(2);

  typedef struct packed {
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
  } span_t;

  // Start and end of the area on one axis; far picks the right or bottom corner
  function automatic span_t axis_span(input logic [CB-1:0] video, input logic [LB-1:0] logo,
                                      input logic far, input logic half);
    logic signed [DW-1:0] v;
    logic signed [DW-1:0] l;
    logic signed [DW-1:0] st;
    logic signed [DW-1:0] en;
    span_t                r;
    v = signed'(DW'(video));
    l = signed'(DW'(logo));
    if (far) begin
      st = v - l;
      en = v - S_ONE;
    end else begin
      st = S_ZERO;
      en = l - S_ONE;
    end
    if (st < S_ZERO) st = S_ZERO;
    if (en < S_ZERO) en = S_ZERO;
    if (en < st) en = st;
    if (half) begin
      st = st >>> 1;
      en = en >>> 1;
    end
    r.lo = st;
    r.hi = en;
    return r;
  endfunction

  // Configuration registers
  logic [CORNER_W-1:0]    logo_corner;
  logic [LOGO_REG_W-1:0]  logo_width;
  logic [LOGO_REG_W-1:0]  logo_height;
  logic [VIDEO_REG_W-1:0] video_width;
  logic [VIDEO_REG_W-1:0] video_height;
  logic [MARGIN_W-1:0]    edge_margin;
  logic                   chroma_plane;
  logic                   compare_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      logo_corner    <= RST_LOGO_CORNER;
      logo_width     <= RST_LOGO_WIDTH;
      logo_height    <= RST_LOGO_HEIGHT;
      video_width    <= RST_VIDEO_WIDTH;
      video_height   <= RST_VIDEO_HEIGHT;
      edge_margin    <= RST_EDGE_MARGIN;
      chroma_plane   <= 1'b0;
      compare_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOGO_CORNER:    logo_corner    <= cfg_data[CORNER_W-1:0];
        CFG_LOGO_WIDTH:     logo_width     <= cfg_data[LOGO_REG_W-1:0];
        CFG_LOGO_HEIGHT:    logo_height    <= cfg_data[LOGO_REG_W-1:0];
        CFG_VIDEO_WIDTH:    video_width    <= cfg_data[VIDEO_REG_W-1:0];
        CFG_VIDEO_HEIGHT:   video_height   <= cfg_data[VIDEO_REG_W-1:0];
        CFG_EDGE_MARGIN:    edge_margin    <= cfg_data[MARGIN_W-1:0];
        CFG_CHROMA_PLANE:   chroma_plane   <= cfg_data[0];
        CFG_COMPARE_ENABLE: compare_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sizes cut to the coordinate and logo widths
  logic [CB+VIDEO_REG_W-1:0] vw_wide;
  logic [CB+VIDEO_REG_W-1:0] vh_wide;
  logic [LB+LOGO_REG_W-1:0]  lw_wide;
  logic [LB+LOGO_REG_W-1:0]  lh_wide;
  logic [CB-1:0]             vw_eff;
  logic [CB-1:0]             vh_eff;
  logic [LB-1:0]             lw_eff;
  logic [LB-1:0]             lh_eff;
  span_t                     x_span;
  span_t                     y_span;

  assign vw_wide = {{CB{1'b0}}, video_width};
  assign vh_wide = {{CB{1'b0}}, video_height};
  assign lw_wide = {{LB{1'b0}}, logo_width};
  assign lh_wide = {{LB{1'b0}}, logo_height};
  assign vw_eff  = vw_wide[CB-1:0];
  assign vh_eff  = vh_wide[CB-1:0];
  assign lw_eff  = lw_wide[LB-1:0];
  assign lh_eff  = lh_wide[LB-1:0];
  assign x_span  = axis_span(vw_eff, lw_eff, logo_corner[0], chroma_plane);
  assign y_span  = axis_span(vh_eff, lh_eff, logo_corner[1], chroma_plane);

  // Bounds, loaded in the first setup state
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] xe;
  logic signed [DW-1:0] ys;
  logic signed [DW-1:0] ye;
  logic signed [DW-1:0] pw;
  logic signed [DW-1:0] ph;
  logic signed [DW-1:0] margin;
  logic [MAG_W-1:0]     cut;
  logic [PROD_W-1:0]    prod;

  always_ff @(posedge clk) begin
    if (cmd.load_bounds) begin
      xs     <= x_span.lo;
      xe     <= x_span.hi;
      ys     <= y_span.lo;
      ye     <= y_span.hi;
      pw     <= chroma_plane ? (signed'(DW'(vw_eff)) >>> 1) : signed'(DW'(vw_eff));
      ph     <= chroma_plane ? (signed'(DW'(vh_eff)) >>> 1) : signed'(DW'(vh_eff));
      margin <= chroma_plane ? signed'(DW'(edge_margin >> 1)) : signed'(DW'(edge_margin));
      cut    <= chroma_plane ? CUT_CHROMA : CUT_LUMA;
      prod   <= PROD_W'(lw_eff) * PROD_W'(lh_eff);
    end
  end

  // Zero-gradient limits, loaded in the second setup state
  logic signed [DW-1:0] x_lo;
  logic signed [DW-1:0] x_hi;
  logic signed [DW-1:0] x_pw;
  logic signed [DW-1:0] y_lo;
  logic signed [DW-1:0] y_hi;
  logic signed [DW-1:0] y_ph;

  always_ff @(posedge clk) begin
    if (cmd.load_limits) begin
      x_lo <= xs + margin;
      x_hi <= xe - margin;
      x_pw <= pw - S_TWO;
      y_lo <= ys + margin;
      y_hi <= ye - margin;
      y_ph <= ph - S_TWO;
    end
  end

  // Window unpack
  logic [PIX_W-1:0] win [WIN_TAPS];
  logic [PIX_W-1:0] mask_pix;

  always_comb begin
    for (int i = 0; i < WIN_TAPS; i++) begin
      win[i] = s_tdata[i*PIX_W +: PIX_W];
    end
  end
  assign mask_pix = s_tdata[WIN_TAPS*PIX_W +: PIX_W];

  // Sobel magnitude
  logic [SOB_W-1:0]        sum_up;
  logic [SOB_W-1:0]        sum_dn;
  logic [SOB_W-1:0]        sum_lt;
  logic [SOB_W-1:0]        sum_rt;
  logic signed [SOB_W:0]   gv;
  logic signed [SOB_W:0]   gh;
  logic [SOB_W-1:0]        av;
  logic [SOB_W-1:0]        ah;
  logic [MAG_W-1:0]        mag;

  assign sum_up = SOB_W'(win[0]) + (SOB_W'(win[1]) << 1) + SOB_W'(win[2]);
  assign sum_dn = SOB_W'(win[6]) + (SOB_W'(win[7]) << 1) + SOB_W'(win[8]);
  assign sum_lt = SOB_W'(win[0]) + (SOB_W'(win[3]) << 1) + SOB_W'(win[6]);
  assign sum_rt = SOB_W'(win[2]) + (SOB_W'(win[5]) << 1) + SOB_W'(win[8]);
  assign gv     = signed'({1'b0, sum_dn}) - signed'({1'b0, sum_up});
  assign gh     = signed'({1'b0, sum_lt}) - signed'({1'b0, sum_rt});
  assign av     = gv[SOB_W] ? SOB_W'(-gv) : SOB_W'(gv);
  assign ah     = gh[SOB_W] ? SOB_W'(-gh) : SOB_W'(gh);
  assign mag    = MAG_W'(av) + MAG_W'(ah);

  // Walker and running totals
  logic [CB-1:0]     column_pos;
  logic [CB-1:0]     row_pos;
  logic [COUNT_W-1:0] match_total;
  logic [COUNT_W-1:0] inverse_total;
  logic [SUM_W-1:0]  intensity_sum;

  logic signed [DW-1:0] xc;
  logic signed [DW-1:0] yc;
  logic                 in_zero;
  logic [PIX_W-1:0]     edge_val;
  logic [PIX_W-1:0]     match_v;
  logic [PIX_W-1:0]     inverse_v;
  logic                 match_hit;
  logic                 inverse_hit;
  logic [COUNT_W-1:0]   match_total_next;
  logic [COUNT_W-1:0]   inverse_total_next;
  logic [SUM_W-1:0]     intensity_sum_next;

  assign xc = signed'(DW'(column_pos));
  assign yc = signed'(DW'(row_pos));

  assign in_zero = (xc < x_lo) || (xc <= S_ZERO) || (xc >= x_hi) || (xc >= x_pw) ||
                   (yc < y_lo) || (yc <= S_ZERO) || (yc > y_hi) || (yc >= y_ph);

  assign edge_val  = (!in_zero && (mag >= cut)) ? '0 : PIX_MAX;
  assign match_v   = mask_pix + edge_val;
  assign inverse_v = ~mask_pix + edge_val;

  assign match_hit   = compare_enable && (match_v == '0) && (match_total != COUNT_MAX);
  assign inverse_hit = compare_enable && (inverse_v == '0) && (inverse_total != COUNT_MAX);
  assign match_total_next   = match_hit ? match_total + 1'b1 : match_total;
  assign inverse_total_next = inverse_hit ? inverse_total + 1'b1 : inverse_total;
  assign intensity_sum_next = chroma_plane ? intensity_sum
                                           : intensity_sum + SUM_W'(win[4]);

  always_ff @(posedge clk) begin
    if (cmd.load_limits || (cmd.take && s_tlast)) begin
      // back to the area start, clear the totals
      column_pos    <= xs[CB-1:0];
      row_pos       <= ys[CB-1:0];
      match_total   <= '0;
      inverse_total <= '0;
      intensity_sum <= '0;
    end else if (cmd.take) begin
      match_total   <= match_total_next;
      inverse_total <= inverse_total_next;
      intensity_sum <= intensity_sum_next;
      if (xc >= xe) begin
        column_pos <= xs[CB-1:0];
        row_pos    <= (yc >= ye) ? ys[CB-1:0] : row_pos + 1'b1;
      end else begin
        column_pos <= column_pos + 1'b1;
      end
    end
  end

  // Mean intensity divider
  logic [MEAN_W-1:0] quotient;

  sle_div #(
    .DIVISOR_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (intensity_sum_next),
    .divisor  (prod),
    .quotient (quotient)
  );

  // Output register
  logic [PIX_W-1:0]       out_edge;
  logic [PIX_W-1:0]       out_match;
  logic [PIX_W-1:0]       out_inverse;
  logic [COUNT_OUT_W-1:0] out_mcount;
  logic [COUNT_OUT_W-1:0] out_icount;
  logic [MEAN_W-1:0]      out_mean;
  logic                   out_last;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_edge    <= edge_val;
      out_match   <= compare_enable ? match_v : '0;
      out_inverse <= compare_enable ? inverse_v : '0;
      out_mcount  <= compare_enable ? COUNT_OUT_W'(match_total_next) : '0;
      out_icount  <= compare_enable ? COUNT_OUT_W'(inverse_total_next) : '0;
      out_mean    <= '0;
      out_last    <= s_tlast;
    end else if (cmd.div_done) begin
      out_mean <= quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((cmd.take && !status.need_div) || cmd.div_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_mean, out_icount, out_mcount,
                    out_inverse, out_match, out_edge};
  assign m_tlast = out_last;

  assign status.out_free = !m_tvalid || m_tready;
  assign status.need_div = s_tlast && !chroma_plane;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (!m_tvalid || m_tready))
    else $error("item taken while a result is stalled");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && s_tlast) |=> (match_total == '0) && (inverse_total == '0) &&
                               (intensity_sum == '0) && (column_pos == xs[CB-1:0]))
    else $error("area state not restarted after the last item");

endmodule

`default_nettype wire

@@ design/sle_ctrl.sv @@
// Controller: setup after reset and configuration, item acceptance, mean division steps.
`default_nettype none

module sle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 s_tvalid,
  input  sle_pkg::dp_status_t  status,
  output sle_pkg::ctrl_cmd_t   cmd,
  output logic                 s_tready
);
  import sle_pkg::*;

  ctrl_state_t            state;
  ctrl_state_t            state_next;
  logic [DIV_COUNT_W-1:0] div_count;
  logic [DIV_COUNT_W-1:0] div_count_next;
  logic                   ready;
  logic                   accept;

  assign ready  = (state == ST_IDLE) && status.out_free && !cfg_write;
  assign accept = ready && s_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RESTART;
      div_count <= '0;
    end else begin
      state     <= state_next;
      div_count <= div_count_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_count_next = (state == ST_DIVIDE) ? div_count + 1'b1 : '0;
    case (state)
      ST_RESTART: state_next = cfg_write ? ST_RESTART : ST_LIMITS;
      ST_LIMITS:  state_next = cfg_write ? ST_RESTART : ST_IDLE;
      ST_IDLE: begin
        if (cfg_write) begin
          state_next = ST_RESTART;
        end else if (accept && status.need_div) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_count == DIV_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH:  state_next = ST_IDLE;
      default:    state_next = ST_RESTART;
    endcase
  end

  always_comb begin
    cmd.load_bounds = (state == ST_RESTART);
    cmd.load_limits = (state == ST_LIMITS);
    cmd.take        = accept;
    cmd.div_start   = accept && status.need_div;
    cmd.div_step    = (state == ST_DIVIDE);
    cmd.div_done    = (state == ST_FINISH);
    s_tready        = ready;
  end

  a_div_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == ST_DIVIDE) && (div_count == '0))
    else $error("divider start not followed by the divide phase");

  a_full_divide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ($past(state) == ST_DIVIDE) && ($past(div_count) == DIV_LAST))
    else $error("mean delivered before all divide steps");

endmodule

`default_nettype wire

@@ design/sobel_logo_edge_matcher.sv @@
// Top level of the Sobel logo edge matcher: controller and datapath.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tlast, one 3x3 window
//   plus mask pixel per item, in raster order over the logo area; s_tlast
//   marks the final pixel of the area. Result items leave on
//   m_tvalid/m_tready/m_tdata/m_tlast, one per input item, with m_tlast set
//   on the result of the final pixel.
//   Flow: a result is registered and shows in the cycle after its item is
//   accepted, so items stream at one per cycle while m_tready stays high. The
//   final item of a luma area also waits for the mean intensity: it comes out
//   of an 8-step restoring divider (one quotient bit per cycle) after a load
//   step, and s_tready stays low meanwhile.
//   Stall: a new item is taken in the cycle the pending result is taken;
//   while a result waits on m_tready, s_tready is low and nothing is lost.
//   Reset and any configuration write start the setup states (bounds, then
//   zero-gradient limits and walker restart) with s_tready low; write
//   configuration only while the block is idle.
`default_nettype none

module sobel_logo_edge_matcher #(
  parameter int COORD_BITS    = sle_pkg::COORD_BITS_DEF,
  parameter int LOGO_DIM_BITS = sle_pkg::LOGO_DIM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port, register index in list order
  input  logic                             cfg_write,
  input  logic [sle_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sle_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pix_up_left, pix_up, pix_up_right, pix_left, pix_center, pix_right,
  // pix_down_left, pix_down, pix_down_right, mask_pixel (8 bits each)
  input  logic [sle_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tlast,    // area_last
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // edge_pixel (8), match_value (8), inverse_value (8), match_count (23),
  // inverse_count (23), mean_intensity (8), zero fill (2)
  output logic [sle_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast     // area_done
);
  import sle_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing: setup after reset or configuration, take, divide, finish
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .s_tvalid  (s_tvalid),
    .status    (status),
    .cmd       (cmd),
    .s_tready  (s_tready)
  );

  // Configuration, area walker, Sobel threshold, counts and output register
  sle_datapath #(
    .COORD_BITS    (COORD_BITS),
    .LOGO_DIM_BITS (LOGO_DIM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
